// File: rtl/core/blsu_pkg.sv
// Shared types and constants for the bounded list with search unit.
package blsu_pkg;

  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned OpcodeW      = 3;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned ItemCountW   = 5;

  typedef enum logic [OpcodeW-1:0] {
    OP_APPEND     = 3'd0,
    OP_PREPEND    = 3'd1,
    OP_DROP_FIRST = 3'd2,
    OP_DROP_LAST  = 3'd3,
    OP_SEARCH     = 3'd4
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_APPEND,
    CMD_PREPEND,
    CMD_DROP_FIRST,
    CMD_SEARCH
  } cell_cmd_e;

endpackage

// File: rtl/core/blsu_if.sv
// Valid/ready channel interfaces for operation and result beats.
interface blsu_in_if import blsu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpcodeW-1:0] opcode;
  logic [ValueW-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface blsu_out_if import blsu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [StatusW-1:0]    status;
  logic                  found;
  logic [ItemCountW-1:0] item_count;

  modport source (output valid, output status, output found, output item_count, input ready);
  modport sink   (input valid, input status, input found, input item_count, output ready);
endinterface

// File: rtl/core/blsu_cell.sv
// One list entry cell: holds a word, shifts with its neighbors, compares on search.
module blsu_cell import blsu_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_cmd_e             cmd_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] entry_o,
  output logic                  match_o
);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic                  match_q, match_d;
  logic                  active;

  assign active = CNT_W'(INDEX) < count_i;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    case (cmd_i)
      CMD_HOLD: ;
      CMD_APPEND: begin
        if (count_i == CNT_W'(INDEX)) entry_d = value_i;
        match_d = 1'b0;
      end
      CMD_PREPEND: begin
        entry_d = left_i;
        match_d = 1'b0;
      end
      CMD_DROP_FIRST: begin
        entry_d = right_i;
        match_d = 1'b0;
      end
      CMD_SEARCH: match_d = active && (entry_q == value_i);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// File: rtl/core/bounded_list_with_search_unit.sv
// Top level of the bounded list with search unit: count control, cell row, result register.
//
//   channel | dir | fields                       | beat accepted when
//   in_i    | in  | opcode, value                | in_i.valid && in_i.ready
//   out_o   | out | status, found, item_count    | out_o.valid && out_o.ready
//
// Each operation beat updates the cell row in its accept cycle; its result is
// formed from the cells' registered match flags once the result register is
// free. One operation per cycle is taken while the result register drains.
// Reset clears the count; entry words are undefined until written.
// A stalled result register holds one finished and one pending result, then in_i stalls.
module bounded_list_with_search_unit import blsu_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  blsu_in_if.sink    in_i,
  blsu_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]      count_q, count_d;
  cell_cmd_e             cmd;
  status_e               status_d;
  logic [DATA_WIDTH-1:0] value;
  logic                  in_fire, out_free, full, empty;

  logic [DATA_WIDTH-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]   match;

  logic      pend_q;
  status_e   pend_status_q;
  logic      pend_search_q;
  logic      out_valid_q;
  status_e   out_status_q;
  logic      out_found_q;
  logic [ItemCountW-1:0] out_count_q;

  assign value    = DATA_WIDTH'(in_i.value);
  assign full     = count_q == CNT_W'(CAPACITY);
  assign empty    = count_q == '0;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = !pend_q || out_free;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    cmd      = CMD_HOLD;
    status_d = ST_DONE;
    count_d  = count_q;
    if (in_fire) begin
      case (in_i.opcode)
        OP_APPEND, OP_PREPEND: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd     = (in_i.opcode == OP_APPEND) ? CMD_APPEND : CMD_PREPEND;
            count_d = count_q + 1'b1;
          end
        end
        OP_DROP_FIRST, OP_DROP_LAST: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            if (in_i.opcode == OP_DROP_FIRST) cmd = CMD_DROP_FIRST;
            count_d = count_q - 1'b1;
          end
        end
        OP_SEARCH: cmd = CMD_SEARCH;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = value;
    end else begin : g_mid
      assign left = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = entry[i];
    end else begin : g_inner
      assign right = entry[i+1];
    end
    blsu_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .count_i (count_q),
      .value_i (value),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[i]),
      .match_o (match[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        pend_q <= 1'b1;
      end else if (out_free) begin
        pend_q <= 1'b0;
      end
      if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // match flags only mean something after a search beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_status_q <= status_d;
      pend_search_q <= (cmd == CMD_SEARCH);
    end
    if (pend_q && out_free) begin
      out_status_q <= pend_status_q;
      out_found_q  <= pend_search_q && (|match);
      out_count_q  <= ItemCountW'(count_q);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.found      = out_found_q;
  assign out_o.item_count = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(count_q))
    else $error("count changed without an operation");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.found |-> out_o.status == ST_DONE)
    else $error("found set on a rejected operation");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !out_free |-> !in_i.ready)
    else $error("operation taken while its predecessor is stuck");

endmodule
